@@ src/shs_pkg.sv @@
`timescale 1ns / 1ps

package shs_pkg;

    // fixed field widths of the stream payloads
    localparam int FIELD_W     = 16;
    localparam int OP_W        = 2;
    localparam int KIND_W      = 3;
    localparam int POS_W       = 4;
    localparam int VALUE_W     = 33;
    localparam int S_TDATA_W   = 2 * FIELD_W;
    localparam int S_TUSER_W   = OP_W;
    localparam int M_TDATA_W   = 40;
    localparam int M_TUSER_W   = KIND_W + 1;
    localparam int M_TDATA_PAD = M_TDATA_W - POS_W - VALUE_W;

    // request codes on the input tuser
    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REPORT = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    // result kinds on the output tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_COUNT  = 3'd0,
        KIND_MAX    = 3'd1,
        KIND_MIN    = 3'd2,
        KIND_LEVELS = 3'd3,
        KIND_BIT    = 3'd4,
        KIND_BIN    = 3'd5
    } t_kind;

endpackage

@@ src/sample_histogram_statistics_unit.sv @@
`timescale 1ns / 1ps

// Histogram and statistics over a stream of signed samples. Each bin of the
// histogram lives in one synchronous memory of 2^SAMPLE_BITS words, updated by
// read-modify-write with forwarding of the word written in the previous cycle,
// so add beats are taken one per cycle without gaps unless a clearing pass,
// report or bin read holds tready low. A bin read passes the memory read, then
// the output register, with tready low meanwhile; a report sends 4 + SAMPLE_BITS
// beats from the statistics registers, one per cycle that the output is free,
// and tready stays low until its last beat is in the output register. After
// reset a clearing pass writes every bin to zero, during which tready is low.
// Counts saturate at 2^COUNT_BITS-1, shown in the low 33 bits of result_value.
module sample_histogram_statistics_unit
    import shs_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave side
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // tdata: sample_value[15:0], bin_index[31:16]
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // tuser: operation[1:0]
    input  logic [S_TUSER_W-1:0] i_s_axis_tuser,
    // master side
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // tdata: bit_position[3:0], result_value[36:4], zero pad[39:37]
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    // tuser: result_kind[2:0], empty_res[3]
    output logic [M_TUSER_W-1:0] o_m_axis_tuser,
    output logic                 o_m_axis_tlast
);

    localparam int NBINS     = 1 << SAMPLE_BITS;
    localparam int REP_LEN   = 4 + SAMPLE_BITS;
    localparam int IDX_W     = $clog2(REP_LEN);
    localparam int BIT_IDX_W = $clog2(SAMPLE_BITS);
    localparam int LVL_W     = SAMPLE_BITS + 1;

    // report slots
    localparam logic [IDX_W-1:0] SLOT_COUNT  = IDX_W'(0);
    localparam logic [IDX_W-1:0] SLOT_MAX    = IDX_W'(1);
    localparam logic [IDX_W-1:0] SLOT_MIN    = IDX_W'(2);
    localparam logic [IDX_W-1:0] SLOT_LEVELS = IDX_W'(3);
    localparam logic [IDX_W-1:0] SLOT_BITS   = IDX_W'(4);
    localparam logic [IDX_W-1:0] SLOT_LAST   = IDX_W'(REP_LEN - 1);

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (&c) ? c : c + COUNT_BITS'(1);
    endfunction

    function automatic logic [VALUE_W-1:0] count_value(input logic [COUNT_BITS-1:0] c);
        logic [COUNT_BITS+VALUE_W-1:0] ext;
        ext = {{VALUE_W{1'b0}}, c};
        return ext[VALUE_W-1:0];
    endfunction

    function automatic logic [VALUE_W-1:0] signed_value(input logic [SAMPLE_BITS-1:0] v);
        return {{(VALUE_W-SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v};
    endfunction

    // histogram memory
    logic [COUNT_BITS-1:0] r_hist [NBINS];

    // clearing pass
    logic                   r_clr_busy;
    logic [SAMPLE_BITS-1:0] r_clr_addr;

    // update stage
    logic                   r_p_valid;
    t_op                    r_p_op;
    logic [SAMPLE_BITS-1:0] r_p_addr;
    logic [COUNT_BITS-1:0]  r_rd_data;
    logic                   r_fwd_hit;
    logic [COUNT_BITS-1:0]  r_fwd_data;

    // statistics
    logic [COUNT_BITS-1:0]         r_count;
    logic signed [SAMPLE_BITS-1:0] r_max;
    logic signed [SAMPLE_BITS-1:0] r_min;
    logic [LVL_W-1:0]              r_levels;
    logic [COUNT_BITS-1:0]         r_bits [SAMPLE_BITS];

    // report sequencer
    logic             r_rep_busy;
    logic [IDX_W-1:0] r_rep_idx;

    // output register
    logic               r_out_valid;
    t_kind              r_out_kind;
    logic [POS_W-1:0]   r_out_pos;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_empty;
    logic               r_out_last;

    t_op                    w_in_op;
    logic                   w_in_known;
    logic                   w_in_acc;
    logic [SAMPLE_BITS-1:0] w_in_addr;
    logic                   w_out_free;
    logic                   w_p_add;
    logic                   w_p_go;
    logic                   w_rep_go;
    logic                   w_empty;
    logic [COUNT_BITS-1:0]  w_old;
    logic [COUNT_BITS-1:0]  w_new;
    logic                   w_we;
    logic [SAMPLE_BITS-1:0] w_wa;
    logic [COUNT_BITS-1:0]  w_wd;
    logic [IDX_W-1:0]       w_bit_off;
    logic                   n_fwd_hit;
    logic                   n_out_load;
    t_kind                  n_out_kind;
    logic [POS_W-1:0]       n_out_pos;
    logic [VALUE_W-1:0]     n_out_value;
    logic                   n_out_last;

    // input decode
    assign w_in_op    = t_op'(i_s_axis_tuser);
    assign w_in_known = (w_in_op == OP_ADD) || (w_in_op == OP_REPORT) || (w_in_op == OP_READ);
    assign w_in_addr  = (w_in_op == OP_ADD) ? i_s_axis_tdata[SAMPLE_BITS-1:0]
                                            : i_s_axis_tdata[FIELD_W +: SAMPLE_BITS];

    // handshake
    assign o_s_axis_tready = !r_clr_busy && !r_rep_busy && !(r_p_valid && r_p_op != OP_ADD);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_p_add         = r_p_valid && (r_p_op == OP_ADD);
    assign w_p_go          = r_p_valid && ((r_p_op != OP_READ) || w_out_free);
    assign w_rep_go        = r_rep_busy && w_out_free;
    assign w_empty         = (r_count == '0);

    // bin increment with forwarding of last cycle's write
    assign w_old     = r_fwd_hit ? r_fwd_data : r_rd_data;
    assign w_new     = sat_inc(w_old);
    assign n_fwd_hit = w_p_add && (r_p_addr == w_in_addr);

    // memory write port, shared by the clearing pass and the update stage
    assign w_we = r_clr_busy || w_p_add;
    assign w_wa = r_clr_busy ? r_clr_addr : r_p_addr;
    assign w_wd = r_clr_busy ? '0 : w_new;

    // result selection for the output register
    assign w_bit_off = r_rep_idx - SLOT_BITS;

    always_comb begin
        n_out_load  = 1'b0;
        n_out_kind  = KIND_BIN;
        n_out_pos   = '0;
        n_out_value = count_value(w_old);
        n_out_last  = 1'b1;
        if (w_rep_go) begin
            n_out_load = 1'b1;
            n_out_last = (r_rep_idx == SLOT_LAST);
            priority if (r_rep_idx == SLOT_COUNT) begin
                n_out_kind  = KIND_COUNT;
                n_out_value = count_value(r_count);
            end else if (r_rep_idx == SLOT_MAX) begin
                n_out_kind  = KIND_MAX;
                n_out_value = w_empty ? '0 : signed_value(r_max);
            end else if (r_rep_idx == SLOT_MIN) begin
                n_out_kind  = KIND_MIN;
                n_out_value = w_empty ? '0 : signed_value(r_min);
            end else if (r_rep_idx == SLOT_LEVELS) begin
                n_out_kind  = KIND_LEVELS;
                n_out_value = {{(VALUE_W-LVL_W){1'b0}}, r_levels};
            end else begin
                n_out_kind  = KIND_BIT;
                n_out_pos   = POS_W'(w_bit_off);
                n_out_value = count_value(r_bits[w_bit_off[BIT_IDX_W-1:0]]);
            end
        end else if (w_p_go && r_p_op == OP_READ) begin
            n_out_load = 1'b1;
        end
    end

    // histogram memory: one write, one registered read on accept
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_hist[w_wa] <= w_wd;
        end
        if (w_in_acc) begin
            r_rd_data <= r_hist[w_in_addr];
        end
    end

    // control and statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_p_valid   <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_rep_busy  <= 1'b0;
            r_rep_idx   <= '0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_max       <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            r_min       <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            r_levels    <= '0;
            for (int b = 0; b < SAMPLE_BITS; b++) begin
                r_bits[b] <= '0;
            end
        end else begin
            // clearing pass
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + SAMPLE_BITS'(1);
                if (&r_clr_addr) begin
                    r_clr_busy <= 1'b0;
                end
            end

            // update stage occupancy
            if (w_in_acc) begin
                r_p_valid <= w_in_known;
                r_fwd_hit <= n_fwd_hit;
            end else if (w_p_go) begin
                r_p_valid <= 1'b0;
            end

            // statistics on an add
            if (w_p_add) begin
                r_count <= sat_inc(r_count);
                if (w_old == '0) begin
                    r_levels <= r_levels + LVL_W'(1);
                end
                if ($signed(r_p_addr) > r_max) begin
                    r_max <= r_p_addr;
                end
                if ($signed(r_p_addr) < r_min) begin
                    r_min <= r_p_addr;
                end
                for (int b = 0; b < SAMPLE_BITS; b++) begin
                    if (r_p_addr[b]) begin
                        r_bits[b] <= sat_inc(r_bits[b]);
                    end
                end
            end

            // report sequencer
            if (w_p_go && r_p_op == OP_REPORT) begin
                r_rep_busy <= 1'b1;
                r_rep_idx  <= '0;
            end else if (w_rep_go) begin
                r_rep_idx <= r_rep_idx + IDX_W'(1);
                if (r_rep_idx == SLOT_LAST) begin
                    r_rep_busy <= 1'b0;
                end
            end

            // output valid
            if (n_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_p_op     <= w_in_op;
            r_p_addr   <= w_in_addr;
            r_fwd_data <= w_new;
        end
        if (n_out_load) begin
            r_out_kind  <= n_out_kind;
            r_out_pos   <= n_out_pos;
            r_out_value <= n_out_value;
            r_out_empty <= w_empty;
            r_out_last  <= n_out_last;
        end
    end

    // output ports
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{M_TDATA_PAD{1'b0}}, r_out_value, r_out_pos};
    assign o_m_axis_tuser  = {r_out_empty, r_out_kind};
    assign o_m_axis_tlast  = r_out_last;

endmodule

@@ src/shs_checker.sv @@
`timescale 1ns / 1ps

module shs_checker
    import shs_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_axis_tvalid,
    input logic                 o_s_axis_tready,
    input logic [S_TDATA_W-1:0] i_s_axis_tdata,
    input logic [S_TUSER_W-1:0] i_s_axis_tuser,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [M_TDATA_W-1:0] o_m_axis_tdata,
    input logic [M_TUSER_W-1:0] o_m_axis_tuser,
    input logic                 o_m_axis_tlast
);

    t_kind w_kind;
    logic  w_empty;

    assign w_kind  = t_kind'(o_m_axis_tuser[KIND_W-1:0]);
    assign w_empty = o_m_axis_tuser[KIND_W];

    // a stalled beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("output beat changed while stalled");

    // a bin read is a single beat
    a_bin_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w_kind == KIND_BIN |-> o_m_axis_tlast)
        else $error("bin count beat without tlast");

    // only bit counts and bin counts close a request
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> w_kind == KIND_BIT || w_kind == KIND_BIN)
        else $error("tlast on a beat that cannot end a request");

    // bit position is zero outside bit counts
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w_kind != KIND_BIT |-> o_m_axis_tdata[POS_W-1:0] == '0)
        else $error("bit position set on a non bit count beat");

    // with no samples, count, max and min read as zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w_empty
            && (w_kind == KIND_COUNT || w_kind == KIND_MAX || w_kind == KIND_MIN)
            |-> o_m_axis_tdata[POS_W +: VALUE_W] == '0)
        else $error("nonzero statistic while empty");

endmodule

bind sample_histogram_statistics_unit shs_checker u_shs_checker (.*);

@@ tb/shs_result_checker.sv @@
`timescale 1ns / 1ps

module shs_result_checker
    import shs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel as seen at the block
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    // tdata: sample_value[15:0], bin_index[31:16]
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // tuser: operation[1:0]
    input  logic [S_TUSER_W-1:0] i_s_tuser,
    // result channel as seen at the block
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    // tdata: bit_position[3:0], result_value[36:4], zero pad[39:37]
    input  logic [M_TDATA_W-1:0] i_m_tdata,
    // tuser: result_kind[2:0], empty_res[3]
    input  logic [M_TUSER_W-1:0] i_m_tuser,
    input  logic                 i_m_tlast,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int NUM_BINS = 1 << FIELD_W;

    typedef struct packed {
        t_kind              kind;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] value;
        logic               empty;
        logic               last;
    } t_result_beat;

    // shadow of the histogram and statistics
    logic [31:0]        hist_bins [0:NUM_BINS-1];
    logic [31:0]        total_samples;
    logic signed [15:0] peak_hi;
    logic signed [15:0] peak_lo;
    logic [16:0]        level_count;
    logic [31:0]        bit_hits [0:FIELD_W-1];

    // results owed by the block, oldest first
    t_result_beat report_beats_due[$];
    int           mismatches = 0;

    function automatic logic [31:0] bump_count(input logic [31:0] c);
        return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

    task automatic owe_beat(input t_kind kind, input logic [POS_W-1:0] pos,
                            input logic [VALUE_W-1:0] value, input logic empty,
                            input logic last);
        t_result_beat b;
        b.kind  = kind;
        b.pos   = pos;
        b.value = value;
        b.empty = empty;
        b.last  = last;
        report_beats_due.push_back(b);
    endtask

    // update the shadow state and queue the results of one request
    task automatic predict_request(input logic [OP_W-1:0] op, input logic [15:0] smp,
                                   input logic [15:0] bin);
        logic was_empty;
        was_empty = (total_samples == 32'd0);
        case (op)
            OP_ADD: begin
                total_samples = bump_count(total_samples);
                if (hist_bins[smp] == 32'd0)
                    level_count = level_count + 17'd1;
                hist_bins[smp] = bump_count(hist_bins[smp]);
                if ($signed(smp) > peak_hi)
                    peak_hi = smp;
                if ($signed(smp) < peak_lo)
                    peak_lo = smp;
                for (int b = 0; b < FIELD_W; b++) begin
                    if (smp[b])
                        bit_hits[b] = bump_count(bit_hits[b]);
                end
            end
            OP_REPORT: begin
                owe_beat(KIND_COUNT, '0, {1'b0, total_samples}, was_empty, 1'b0);
                owe_beat(KIND_MAX, '0, was_empty ? '0 : {{17{peak_hi[15]}}, peak_hi},
                         was_empty, 1'b0);
                owe_beat(KIND_MIN, '0, was_empty ? '0 : {{17{peak_lo[15]}}, peak_lo},
                         was_empty, 1'b0);
                owe_beat(KIND_LEVELS, '0, {16'd0, level_count}, was_empty, 1'b0);
                for (int b = 0; b < FIELD_W; b++)
                    owe_beat(KIND_BIT, POS_W'(b), {1'b0, bit_hits[b]}, was_empty,
                             b == FIELD_W - 1);
            end
            OP_READ: begin
                owe_beat(KIND_BIN, '0, {1'b0, hist_bins[bin]}, was_empty, 1'b1);
            end
            default: begin
                // spare code leaves everything alone
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: result %s mismatch: expected %0h, got %0h",
                     $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result_beat want;
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_BINS; k++)
                hist_bins[k] = 32'd0;
            for (int b = 0; b < FIELD_W; b++)
                bit_hits[b] = 32'd0;
            total_samples = 32'd0;
            peak_hi       = 16'sh8000;
            peak_lo       = 16'sh7FFF;
            level_count   = 17'd0;
            report_beats_due.delete();
        end else begin
            // result beat first: it always belongs to an earlier request
            if (i_m_tvalid && i_m_tready) begin
                if (report_beats_due.size() == 0) begin
                    $display({"%0t ns: unexpected result beat: expected none, ",
                              "got kind %0d value %0h"},
                             $time, i_m_tuser[KIND_W-1:0], i_m_tdata[POS_W +: VALUE_W]);
                    mismatches++;
                end else begin
                    want = report_beats_due.pop_front();
                    check_field("kind", VALUE_W'(want.kind),
                                VALUE_W'(i_m_tuser[KIND_W-1:0]));
                    check_field("bit_position", VALUE_W'(want.pos),
                                VALUE_W'(i_m_tdata[POS_W-1:0]));
                    check_field("value", want.value, i_m_tdata[POS_W +: VALUE_W]);
                    check_field("empty", VALUE_W'(want.empty), VALUE_W'(i_m_tuser[KIND_W]));
                    check_field("last", VALUE_W'(want.last), VALUE_W'(i_m_tlast));
                end
            end
            // request beat
            if (i_s_tvalid && i_s_tready)
                predict_request(i_s_tuser, i_s_tdata[15:0], i_s_tdata[31:16]);
        end
        o_pending    <= report_beats_due.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ tb/sample_histogram_statistics_unit_tb.sv @@
`timescale 1ns / 1ps

module sample_histogram_statistics_unit_tb;
    import shs_pkg::*;

    // spare request code, ignored by the block
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 360;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 s_tvalid   = 1'b0;
    logic                 s_tready;
    // tdata: sample_value[15:0], bin_index[31:16]
    logic [S_TDATA_W-1:0] s_tdata    = '0;
    // tuser: operation[1:0]
    logic [S_TUSER_W-1:0] s_tuser    = '0;
    logic                 m_tvalid;
    logic                 m_tready   = 1'b0;
    // tdata: bit_position[3:0], result_value[36:4], zero pad[39:37]
    logic [M_TDATA_W-1:0] m_tdata;
    // tuser: result_kind[2:0], empty_res[3]
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;
    int                   fail_count;
    int                   pending;
    logic                 steady     = 1'b0;
    int                   sink_stall = 0;
    int                   sink_draw;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    sample_histogram_statistics_unit uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    shs_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // result sink: random stall after each beat taken
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready   <= 1'b1;
            sink_stall <= 0;
        end else if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            if (sink_stall == 1)
                m_tready <= 1'b1;
        end else if (m_tready && m_tvalid) begin
            sink_draw = steady ? 0 : $urandom_range(0, 5);
            if (sink_draw > 0) begin
                m_tready   <= 1'b0;
                sink_stall <= sink_draw;
            end
        end
    end

    // one request beat, after a random gap, held until taken
    task automatic issue_request(input logic [OP_W-1:0] op, input logic [15:0] smp,
                                 input logic [15:0] bin);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {bin, smp};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    initial begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        logic [15:0]     level_pool [0:7];
        logic [15:0]     added[$];
        logic [15:0]     smp;
        logic [15:0]     bin;
        logic [OP_W-1:0] op;
        int              roll;
        int              sent;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // empty state, spare code, extremes and repeats
        issue_request(OP_REPORT, 16'hFFFF, 16'hFFFF);
        issue_request(OP_READ, 16'h1234, 16'h0000);
        issue_request(OP_SPARE, 16'hFFFF, 16'hFFFF);
        issue_request(OP_ADD, 16'h8000, 16'h0000);
        issue_request(OP_REPORT, 16'h0000, 16'h0000);
        issue_request(OP_ADD, 16'h7FFF, 16'hFFFF);
        issue_request(OP_ADD, 16'h0000, 16'h5555);
        issue_request(OP_ADD, 16'hFFFF, 16'hAAAA);
        issue_request(OP_ADD, 16'h5555, 16'h0000);
        issue_request(OP_ADD, 16'hAAAA, 16'h0000);
        issue_request(OP_ADD, 16'h7FFF, 16'h0000);
        issue_request(OP_READ, 16'h0000, 16'h7FFF);
        issue_request(OP_READ, 16'hFFFF, 16'h8000);
        issue_request(OP_READ, 16'h0000, 16'h0001);
        issue_request(OP_SPARE, 16'h1234, 16'h5678);
        issue_request(OP_REPORT, 16'hAAAA, 16'h5555);
        issue_request(OP_ADD, 16'h0001, 16'hFFFF);
        issue_request(OP_READ, 16'h0000, 16'hFFFF);
        issue_request(OP_READ, 16'hFFFF, 16'h0000);
        issue_request(OP_REPORT, 16'h0000, 16'h0000);

        // random mix, samples mostly from a small set of levels
        level_pool[0] = 16'h8000;
        level_pool[1] = 16'h7FFF;
        for (int k = 2; k < 8; k++)
            level_pool[k] = 16'($urandom);
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent % 40 == 0)
                steady = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 58)
                op = OP_ADD;
            else if (roll < 72)
                op = OP_REPORT;
            else if (roll < 94)
                op = OP_READ;
            else
                op = OP_SPARE;
            if ($urandom_range(0, 9) < 6)
                smp = level_pool[$urandom_range(0, 7)];
            else
                smp = 16'($urandom);
            if (added.size() > 0 && $urandom_range(0, 9) < 7)
                bin = added[$urandom_range(0, added.size() - 1)];
            else
                bin = 16'($urandom);
            issue_request(op, smp, bin);
            if (op == OP_ADD)
                added.push_back(smp);
            if (op != OP_SPARE)
                sent++;
        end
        s_tvalid <= 1'b0;
        steady = 1'b0;

        // let the checker count the last request, drain, then wait for stray beats
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
